// ===== hdl/swsf_pkg.sv =====
// ----------------------------------------------------------------------------
// swsf_pkg: shared types and constants of the sinc window smoothing filter
// Sample, tap and accumulator widths, the raw sinc weight table, the weight
// sum used to normalize the taps, the sequencer states and the window control.
// ----------------------------------------------------------------------------
package swsf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = 16;
    localparam int PAIR_W    = SAMPLE_W + 1;
    localparam int PROD_W    = PAIR_W + TAP_W;
    localparam int ACC_W     = 40;
    localparam int FRAC_BITS = 15;

    // Rounding bias on the accumulator scale and saturation limits on the output scale
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(-32768);

    // Raw Q1.15 weights round(32768 * sin(k/4) / (k/4))
    localparam int RAW_WEIGHT [64] = '{
        32768, 32428, 31420, 29781, 27573, 24877, 21791, 18425,
        14898, 11332, 7844, 4548, 1541, -1091, -3284, -4994,
        -6200, -6900, -7118, -6894, -6284, -5361, -4203, -2897,
        -1526, -174, 1084, 2185, 3075, 3720, 4098, 4205,
        4052, 3664, 3078, 2340, 1500, 616, -259, -1074,
        -1783, -2349, -2745, -2957, -2979, -2819, -2495, -2032,
        -1465, -832, -174, 469, 1059, 1562, 1951, 2207,
        2319, 2285, 2113, 1817, 1421, 950, 436, -87
    };

    // Sum of all raw weights of a window with the given taps per side
    function automatic longint raw_sum(input int taps);
        longint s;
        s = longint'(RAW_WEIGHT[0]);
        for (int k = 1; k <= taps; k++) begin
            s = s + 2 * longint'(RAW_WEIGHT[k & 63]);
        end
        if (s <= 0) begin
            s = 1;
        end
        return s;
    endfunction

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT,
        ST_FLUSH
    } swsf_state_t;

    // Window chain control
    typedef struct packed {
        logic load_all;
        logic shift;
    } win_ctrl_t;

endpackage

// ===== hdl/swsf_sample_cell.sv =====
// ----------------------------------------------------------------------------
// swsf_sample_cell: one sample of the filter window
// Holds one sample; loads the fill value on a sequence start or takes the
// neighbor's sample on a shift.
// ----------------------------------------------------------------------------
module swsf_sample_cell (
    input  logic                                  aclk,
    input  swsf_pkg::win_ctrl_t                   ctrl,
    input  logic signed [swsf_pkg::SAMPLE_W-1:0] fill_in,
    input  logic signed [swsf_pkg::SAMPLE_W-1:0] shift_in,
    output logic signed [swsf_pkg::SAMPLE_W-1:0] sample_out
);

    logic signed [swsf_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [swsf_pkg::SAMPLE_W-1:0] sample_next;

    // Select fill, shift or hold
    always_comb begin
        sample_next = sample_reg;
        if (ctrl.load_all) begin
            sample_next = fill_in;
        end else if (ctrl.shift) begin
            sample_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
    end

    assign sample_out = sample_reg;

endmodule

// ===== hdl/swsf_mac_cell.sv =====
// ----------------------------------------------------------------------------
// swsf_mac_cell: one tap of the symmetric accumulator chain
// Adds the two window samples at equal distance from the center, multiplies
// by the normalized tap and adds the product to the neighbor's partial sum.
// ----------------------------------------------------------------------------
module swsf_mac_cell #(
    parameter int TAPS_PER_SIDE = 29,
    parameter int TAP_IDX       = 0
) (
    input  logic                                  aclk,
    input  logic signed [swsf_pkg::ACC_W-1:0]    acc_in,
    input  logic signed [swsf_pkg::SAMPLE_W-1:0] near_sample,
    input  logic signed [swsf_pkg::SAMPLE_W-1:0] far_sample,
    output logic signed [swsf_pkg::ACC_W-1:0]    acc_out
);

    localparam int     TW      = swsf_pkg::TAP_W;
    localparam int     AW      = swsf_pkg::ACC_W;
    localparam int     PW      = swsf_pkg::PAIR_W;
    localparam longint WSUM    = swsf_pkg::raw_sum(TAPS_PER_SIDE);
    localparam longint RAW     = longint'(swsf_pkg::RAW_WEIGHT[TAP_IDX & 63]);
    localparam longint MAG     = (RAW < 0) ? -RAW : RAW;
    localparam longint QUO     = (MAG * 65536 + WSUM) / (2 * WSUM);
    localparam logic signed [TW-1:0] TAP = TW'((RAW < 0) ? -QUO : QUO);

    logic signed [PW-1:0]                  pair;
    logic signed [swsf_pkg::PROD_W-1:0]    prod;
    logic signed [AW-1:0]                  acc_reg;
    logic signed [AW-1:0]                  acc_next;

    // Fold the symmetric pair, weight it and extend the partial sum
    always_comb begin
        pair     = PW'(near_sample) + PW'(far_sample);
        prod     = pair * TAP;
        acc_next = acc_in + AW'(prod);
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule

// ===== hdl/sinc_window_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// sinc_window_smoothing_filter: 2*T+1 tap symmetric sinc smoothing filter
// A chain of sample cells holds the window; a chain of T+1 tap cells passes
// the partial sum one cell per cycle; a small sequencer handles start, steady
// stream and the end-of-sequence flush with copies of the last sample.
// ----------------------------------------------------------------------------
// Timing: a full window's partial sum crosses the T+1 registered tap cells
//   in CALC; EMIT then loads the result into the output register.
// Throughput: fill-only items are taken one per cycle; with the window full
//   the input is held off until the result is loaded, also through output
//   stalls; the flush shifts in copies of the last sample, then emits each pending result.
// Reset: synchronous, active low; clears the sequencer, fill count and output
//   valid; the window is loaded from the first sample of each sequence.
// ----------------------------------------------------------------------------
module sinc_window_smoothing_filter #(
    parameter int TAPS_PER_SIDE = 29
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [swsf_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                  s_final_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [swsf_pkg::SAMPLE_W-1:0] m_smoothed,
    output logic                                  m_end_of_run
);

    localparam int WIN_LEN = 2 * TAPS_PER_SIDE + 1;
    localparam int CNT_W   = $clog2(TAPS_PER_SIDE + 1);
    localparam int SW      = swsf_pkg::SAMPLE_W;
    localparam int AW      = swsf_pkg::ACC_W;
    localparam logic [CNT_W-1:0] T_CNT = CNT_W'(TAPS_PER_SIDE);
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

    swsf_pkg::swsf_state_t state_reg, state_next;
    swsf_pkg::win_ctrl_t   win_ctrl;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0] pd_reg, pd_next;
    logic             last_reg, last_next;
    logic             flush_reg, flush_next;
    logic signed [SW-1:0] x_reg, x_next;

    logic             m_valid_reg, m_valid_next;
    logic signed [SW-1:0] m_smoothed_reg, m_smoothed_next;
    logic             m_end_reg, m_end_next;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic signed [SW-1:0] win_in;
    logic signed [SW-1:0] win [WIN_LEN];
    logic signed [AW-1:0] acc_chain [TAPS_PER_SIDE + 1];
    logic signed [AW-1:0] acc_rnd;
    logic signed [AW-1:0] acc_sh;
    logic signed [SW-1:0] result;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign win_in   = (state_reg == swsf_pkg::ST_IDLE) ? s_sample : x_reg;

    // Window: sample cells, newest first
    for (genvar i = 0; i < WIN_LEN; i++) begin : g_win
        if (i == 0) begin : g_head
            swsf_sample_cell u_cell (
                .aclk       (aclk),
                .ctrl       (win_ctrl),
                .fill_in    (win_in),
                .shift_in   (win_in),
                .sample_out (win[i])
            );
        end else begin : g_body
            swsf_sample_cell u_cell (
                .aclk       (aclk),
                .ctrl       (win_ctrl),
                .fill_in    (win_in),
                .shift_in   (win[i-1]),
                .sample_out (win[i])
            );
        end
    end

    // Tap chain: center tap first, partial sum moves one cell per cycle
    for (genvar k = 0; k <= TAPS_PER_SIDE; k++) begin : g_tap
        if (k == 0) begin : g_center
            swsf_mac_cell #(
                .TAPS_PER_SIDE (TAPS_PER_SIDE),
                .TAP_IDX       (k)
            ) u_cell (
                .aclk        (aclk),
                .acc_in      ('0),
                .near_sample (win[TAPS_PER_SIDE]),
                .far_sample  ('0),
                .acc_out     (acc_chain[k])
            );
        end else begin : g_side
            swsf_mac_cell #(
                .TAPS_PER_SIDE (TAPS_PER_SIDE),
                .TAP_IDX       (k)
            ) u_cell (
                .aclk        (aclk),
                .acc_in      (acc_chain[k-1]),
                .near_sample (win[TAPS_PER_SIDE-k]),
                .far_sample  (win[TAPS_PER_SIDE+k]),
                .acc_out     (acc_chain[k])
            );
        end
    end

    // Round to nearest and saturate the finished sum
    always_comb begin
        acc_rnd = acc_chain[TAPS_PER_SIDE] + swsf_pkg::ACC_RND;
        acc_sh  = acc_rnd >>> swsf_pkg::FRAC_BITS;
        if (acc_sh > swsf_pkg::SAT_HI) begin
            result = SW'(swsf_pkg::SAT_HI);
        end else if (acc_sh < swsf_pkg::SAT_LO) begin
            result = SW'(swsf_pkg::SAT_LO);
        end else begin
            result = SW'(acc_sh);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swsf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (fill_reg == T_CNT) begin
                        state_next = swsf_pkg::ST_CALC;
                    end else if (s_final_sample) begin
                        state_next = swsf_pkg::ST_FLUSH;
                    end
                end
            end
            swsf_pkg::ST_CALC: begin
                if (cnt_reg == T_CNT) begin
                    state_next = swsf_pkg::ST_EMIT;
                end
            end
            swsf_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (!flush_reg) begin
                        state_next = last_reg ? swsf_pkg::ST_FLUSH : swsf_pkg::ST_IDLE;
                    end else begin
                        state_next = (pd_reg == ONE) ? swsf_pkg::ST_IDLE
                                                     : swsf_pkg::ST_CALC;
                    end
                end
            end
            swsf_pkg::ST_FLUSH: begin
                if (sh_reg == ONE) begin
                    state_next = swsf_pkg::ST_CALC;
                end
            end
            default: state_next = swsf_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready           = (state_reg == swsf_pkg::ST_IDLE);
        out_load          = (state_reg == swsf_pkg::ST_EMIT) && out_free;
        win_ctrl.load_all = accept && (fill_reg == '0);
        win_ctrl.shift    = (accept && (fill_reg != '0))
                         || (state_reg == swsf_pkg::ST_FLUSH)
                         || (out_load && flush_reg && (pd_reg != ONE));
    end

    // Counters, captured item and output register
    always_comb begin
        fill_next       = fill_reg;
        sh_next         = sh_reg;
        pd_next         = pd_reg;
        last_next       = last_reg;
        flush_next      = flush_reg;
        x_next          = x_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        m_smoothed_next = m_smoothed_reg;
        m_end_next      = m_end_reg;

        // Capture item and plan the flush
        if (accept) begin
            x_next     = s_sample;
            last_next  = s_final_sample;
            flush_next = 1'b0;
            if (fill_reg == T_CNT) begin
                pd_next = T_CNT;
                sh_next = ONE;
            end else begin
                pd_next = fill_reg + ONE;
                sh_next = T_CNT - fill_reg;
            end
            if (s_final_sample) begin
                fill_next = '0;
            end else if (fill_reg != T_CNT) begin
                fill_next = fill_reg + ONE;
            end
        end

        // Count flush copies of the last sample
        if (state_reg == swsf_pkg::ST_FLUSH) begin
            sh_next = sh_reg - ONE;
            if (sh_reg == ONE) begin
                flush_next = 1'b1;
            end
        end

        // Advance to the next pending result
        if (out_load && flush_reg) begin
            pd_next = pd_reg - ONE;
        end

        // Time the tap chain settling
        if (state_reg == swsf_pkg::ST_CALC) begin
            cnt_next = cnt_reg + ONE;
        end
        if ((state_next == swsf_pkg::ST_CALC) && (state_reg != swsf_pkg::ST_CALC)) begin
            cnt_next = '0;
        end

        // Load or drop the output item
        if (out_load) begin
            m_valid_next    = 1'b1;
            m_smoothed_next = result;
            m_end_next      = flush_reg && (pd_reg == ONE);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swsf_pkg::ST_IDLE;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            sh_reg      <= '0;
            pd_reg      <= '0;
            last_reg    <= 1'b0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            sh_reg      <= sh_next;
            pd_reg      <= pd_next;
            last_reg    <= last_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        m_smoothed_reg <= m_smoothed_next;
        m_end_reg      <= m_end_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_smoothed   = m_smoothed_reg;
    assign m_end_of_run = m_end_reg;

endmodule

// ===== hdl/swsf_port_check.sv =====
// ----------------------------------------------------------------------------
// swsf_port_check: port-level checks of the smoothing filter
// Watches the handshakes over time and is bound to the top level.
// ----------------------------------------------------------------------------
module swsf_port_check (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic signed [swsf_pkg::SAMPLE_W-1:0] s_sample,
    input logic                                  s_final_sample,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [swsf_pkg::SAMPLE_W-1:0] m_smoothed,
    input logic                                  m_end_of_run
);

    // Hold a waiting input item
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample) && $stable(s_final_sample))
        else $error("input item changed while waiting");

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smoothed) && $stable(m_end_of_run))
        else $error("result item changed while stalled");

    // Drop output valid on reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid survived reset");

    // Stop taking items while the flush after a final item runs
    a_final_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_sample |=> !s_ready)
        else $error("input ready right after a final item");

    // Produce a new result only while input is held off
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while input was open");

endmodule

bind sinc_window_smoothing_filter swsf_port_check u_port_check (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_sample       (s_sample),
    .s_final_sample (s_final_sample),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_smoothed     (m_smoothed),
    .m_end_of_run   (m_end_of_run)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of sinc_window_smoothing_filter
// Drives sample sequences through a valid/ready input with random gaps and
// drains results through a randomly stalled output. A bit-exact predictor of
// the 59-tap normalized sinc filter, including edge replication and the
// end-of-sequence flush, queues the expected items for the output checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int TPS         = 29;
    localparam int SW          = swsf_pkg::SAMPLE_W;
    localparam int WIN_LEN     = 2 * TPS + 1;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 280;
    localparam int DIR_ROWS    = 17;

    typedef struct packed {
        logic signed [swsf_pkg::SAMPLE_W-1:0] smoothed;
        logic                                 end_of_run;
    } smooth_item_t;

    typedef struct packed {
        logic signed [swsf_pkg::SAMPLE_W-1:0] sample;
        logic                                 last;
        logic                                 typed;
        logic signed [swsf_pkg::SAMPLE_W-1:0] smoothed;
    } stim_row_t;

    // Sample sequences for the directed part; typed rows carry their result
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{16'h0000, 1'b1, 1'b1, 16'h0000},
        '{16'h7FFF, 1'b1, 1'b0, 16'h0000},
        '{16'h8000, 1'b1, 1'b0, 16'h0000},
        '{16'h0001, 1'b1, 1'b0, 16'h0000},
        '{16'hFFFF, 1'b1, 1'b0, 16'h0000},
        '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
        '{16'h8000, 1'b0, 1'b0, 16'h0000},
        '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
        '{16'h8000, 1'b1, 1'b0, 16'h0000},
        '{16'h0000, 1'b1, 1'b1, 16'h0000},
        '{16'h5555, 1'b0, 1'b0, 16'h0000},
        '{16'hAAAA, 1'b0, 1'b0, 16'h0000},
        '{16'h00FF, 1'b0, 1'b0, 16'h0000},
        '{16'h7F00, 1'b0, 1'b0, 16'h0000},
        '{16'hFF00, 1'b1, 1'b0, 16'h0000},
        '{16'h0100, 1'b0, 1'b0, 16'h0000},
        '{16'h0100, 1'b1, 1'b0, 16'h0000}
    };

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [swsf_pkg::SAMPLE_W-1:0] s_sample;
    logic                                 s_final_sample;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [swsf_pkg::SAMPLE_W-1:0] m_smoothed;
    logic                                 m_end_of_run;

    // Filter state mirrored by the predictor
    logic signed [swsf_pkg::SAMPLE_W-1:0] sample_window [WIN_LEN];
    int                                   held_count;
    longint                               norm_tap [TPS+1];

    smooth_item_t smoothed_due [$];
    int           fault_count = 0;
    int           idle_cycles = 0;
    logic         tx_quiet;
    logic         rx_quiet;

    sinc_window_smoothing_filter #(
        .TAPS_PER_SIDE (TPS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_final_sample (s_final_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_smoothed     (m_smoothed),
        .m_end_of_run   (m_end_of_run)
    );

    always #4 aclk = ~aclk;

    // Normalize the raw sinc weights to Q1.15, halves away from zero
    function automatic void build_taps();
        longint weight_sum;
        longint r;
        longint mag;
        longint q;
        weight_sum = longint'(swsf_pkg::RAW_WEIGHT[0]);
        for (int k = 1; k <= TPS; k++) begin
            weight_sum += 2 * longint'(swsf_pkg::RAW_WEIGHT[k]);
        end
        if (weight_sum <= 0) begin
            weight_sum = 1;
        end
        for (int k = 0; k <= TPS; k++) begin
            r   = longint'(swsf_pkg::RAW_WEIGHT[k]);
            mag = (r < 0) ? -r : r;
            q   = (mag * 65536 + weight_sum) / (2 * weight_sum);
            norm_tap[k] = (r < 0) ? -q : q;
        end
    endfunction

    // Shift a sample in at the newest end of the window
    function automatic void shift_in(logic signed [swsf_pkg::SAMPLE_W-1:0] x);
        for (int i = WIN_LEN - 1; i > 0; i--) begin
            sample_window[i] = sample_window[i-1];
        end
        sample_window[0] = x;
    endfunction

    // Weighted sum around the centre, rounded and saturated to 16 bits
    function automatic logic signed [swsf_pkg::SAMPLE_W-1:0] centre_smooth();
        longint acc;
        longint y;
        acc = norm_tap[0] * longint'(sample_window[TPS]);
        for (int k = 1; k <= TPS; k++) begin
            acc += norm_tap[k] * (longint'(sample_window[TPS-k]) +
                                  longint'(sample_window[TPS+k]));
        end
        y = (acc + 16384) >>> 15;
        if (y > 32767) begin
            y = 32767;
        end
        if (y < -32768) begin
            y = -32768;
        end
        return y[SW-1:0];
    endfunction

    // Advance the predictor by one accepted item and queue its results
    function automatic void absorb_sample(logic signed [swsf_pkg::SAMPLE_W-1:0] x,
                                          logic last);
        int held;
        int pending;
        held = held_count;
        if (held == 0) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                sample_window[i] = x;
            end
        end else begin
            shift_in(x);
        end
        if (held >= TPS) begin
            smoothed_due.push_back('{centre_smooth(), 1'b0});
        end
        if (!last) begin
            if (held < TPS) begin
                held_count = held + 1;
            end
            return;
        end
        // Flush with copies of the last sample
        pending = (held >= TPS) ? TPS : held + 1;
        for (int i = 0; i < TPS - pending + 1; i++) begin
            shift_in(x);
        end
        for (int i = 0; i < pending; i++) begin
            if (i > 0) begin
                shift_in(x);
            end
            smoothed_due.push_back('{centre_smooth(), i == pending - 1});
        end
        for (int i = 0; i < WIN_LEN; i++) begin
            sample_window[i] = '0;
        end
        held_count = 0;
    endfunction

    function automatic int unsigned pick_gap(logic quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Offer one item at the falling edge and hold it until accepted
    task automatic send_sample(logic signed [swsf_pkg::SAMPLE_W-1:0] x, logic last,
                               logic typed,
                               logic signed [swsf_pkg::SAMPLE_W-1:0] typed_val);
        int unsigned gap;
        int          queued;
        if ($urandom_range(0, 29) == 0) begin
            tx_quiet = ~tx_quiet;
        end
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample       <= x;
        s_final_sample <= last;
        do @(posedge aclk); while (!s_ready);
        queued = smoothed_due.size();
        absorb_sample(x, last);
        if (typed) begin
            while (smoothed_due.size() > queued) begin
                void'(smoothed_due.pop_back());
            end
            smoothed_due.push_back('{typed_val, 1'b1});
        end
        @(negedge aclk);
    endtask

    // One sequence of random content, final item marked
    task automatic send_sequence(int len, int flavor);
        logic signed [swsf_pkg::SAMPLE_W-1:0] x;
        for (int i = 0; i < len; i++) begin
            case (flavor)
                0: begin
                    x = SW'($urandom_range(0, 65535));
                end
                1: begin
                    x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                end
                2: begin
                    x = SW'($urandom_range(0, 1023) - 512);
                end
                3: begin
                    x = ((i / 32) % 2 == 0) ? 16'h7FFF : 16'h8000;
                end
                default: begin
                    x = SW'((i * 1024) - 32768);
                end
            endcase
            send_sample(x, i == len - 1, 1'b0, '0);
        end
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (smoothed_due.size() == 0) begin
                $display("%0t: result with nothing due, smoothed=%0d end_of_run=%0b",
                         $time, m_smoothed, m_end_of_run);
                fault_count++;
            end else begin
                if (m_smoothed !== smoothed_due[0].smoothed) begin
                    $display("%0t: smoothed expected %0d, actual %0d",
                             $time, smoothed_due[0].smoothed, m_smoothed);
                    fault_count++;
                end
                if (m_end_of_run !== smoothed_due[0].end_of_run) begin
                    $display("%0t: end_of_run expected %0b, actual %0b",
                             $time, smoothed_due[0].end_of_run, m_end_of_run);
                    fault_count++;
                end
                void'(smoothed_due.pop_front());
            end
        end
    end

    // Watchdog: count cycles in which neither side moves an item
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("sinc_window_smoothing_filter verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drain results with random stalls
    initial begin
        int unsigned stall;
        rx_quiet = 1'b0;
        m_ready  = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                rx_quiet = ~rx_quiet;
            end
            stall = pick_gap(rx_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        int sent;
        int len;
        int flavor;
        int pick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_sample       = '0;
        s_final_sample = 1'b0;
        tx_quiet       = 1'b0;
        held_count     = 0;
        for (int i = 0; i < WIN_LEN; i++) begin
            sample_window[i] = '0;
        end
        build_taps();

        // Hold reset, then release it at a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_sample(DIRECTED[r].sample, DIRECTED[r].last,
                        DIRECTED[r].typed, DIRECTED[r].smoothed);
        end

        // Random sequences: mostly full windows, some short ones
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick   = $urandom_range(0, 9);
            flavor = $urandom_range(0, 4);
            if (flavor == 3) begin
                len = $urandom_range(60, 100);
            end else if (pick < 2) begin
                len = $urandom_range(1, 28);
            end else if (pick == 2) begin
                len = $urandom_range(29, 31);
            end else begin
                len = $urandom_range(32, 90);
            end
            send_sequence(len, flavor);
            sent += len;
        end
        s_valid <= 1'b0;

        // Let every due result arrive, then watch for strays
        while (smoothed_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * (TPS + 3)) @(posedge aclk);

        if (fault_count == 0) begin
            $display("sinc_window_smoothing_filter verification clean");
        end else begin
            $display("sinc_window_smoothing_filter verification failed");
        end
        $finish;
    end

endmodule
